/* rtl/core/fud_pkg.sv */
`timescale 1ns / 1ps

package fud_pkg;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_KEY   = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_END   = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	// Escape phase, one-hot
	typedef enum logic [2:0] {
		PH_PLAIN = 3'b001,
		PH_HIGH  = 3'b010,
		PH_LOW   = 3'b100
	} phase_t;

	localparam logic [7:0] CHAR_PCT   = 8'h25;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_AMP   = 8'h26;
	localparam logic [7:0] CHAR_EQ    = 8'h3D;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Result queue depth; one request may push two results
	localparam int QDepth   = 4;
	localparam int QPtrW    = $clog2(QDepth);
	localparam int QCountW  = $clog2(QDepth + 1);

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       run_last;
	} result_t;

	typedef struct packed {
		phase_t phase;
		logic   draining;
	} dec_status_t;

	// Hex digit: bit 4 set when valid, low nibble is the value
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

/* rtl/core/fud_decode.sv */
`timescale 1ns / 1ps

module fud_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic                pmode,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output fud_pkg::result_t    res0,
	output fud_pkg::result_t    res1,
	output logic [1:0]          res_count,
	output fud_pkg::dec_status_t status
);
	import fud_pkg::*;

	phase_t     phase_q;
	logic       in_value_q;
	logic [3:0] high_nibble_q;
	logic       draining_q;

	phase_t     phase_d;
	logic       in_value_d;
	logic [3:0] high_nibble_d;
	logic       draining_d;

	logic       p1_valid;
	kind_t      p1_kind;
	logic [7:0] p1_byte;
	logic       p2_valid;
	kind_t      p2_kind;
	kind_t      data_kind;
	logic [4:0] hex;

	assign data_kind = (pmode && in_value_q) ? KIND_VALUE : KIND_KEY;
	assign hex       = hex_decode(data_byte);

	// Decode the byte, then apply end of message
	always_comb begin
		phase_d       = phase_q;
		in_value_d    = in_value_q;
		high_nibble_d = high_nibble_q;
		draining_d    = draining_q;
		p1_valid      = 1'b0;
		p1_kind       = KIND_KEY;
		p1_byte       = 8'd0;
		p2_valid      = 1'b0;
		p2_kind       = KIND_END;
		if (!draining_q) begin
			if (phase_q == PH_PLAIN) begin
				if (data_byte == CHAR_PCT) begin
					phase_d = PH_HIGH;
				end else if (data_byte == CHAR_NUL || (pmode && data_byte == CHAR_AMP)) begin
					p1_valid   = 1'b1;
					p1_kind    = KIND_END;
					in_value_d = 1'b0;
					if (!pmode) begin
						draining_d = 1'b1;
					end
				end else if (pmode && !in_value_q && data_byte == CHAR_EQ) begin
					in_value_d = 1'b1;
				end else begin
					p1_valid = 1'b1;
					p1_kind  = data_kind;
					p1_byte  = (data_byte == CHAR_PLUS) ? CHAR_SPACE : data_byte;
				end
			end else if (!hex[4]) begin
				p1_valid   = 1'b1;
				p1_kind    = KIND_ERROR;
				draining_d = 1'b1;
				phase_d    = PH_PLAIN;
			end else if (phase_q == PH_HIGH) begin
				high_nibble_d = hex[3:0];
				phase_d       = PH_LOW;
			end else begin
				p1_valid = 1'b1;
				p1_kind  = data_kind;
				p1_byte  = {high_nibble_q, hex[3:0]};
				phase_d  = PH_PLAIN;
			end
		end
		if (last_byte) begin
			if (!draining_d) begin
				p2_valid = 1'b1;
				p2_kind  = (phase_d != PH_PLAIN) ? KIND_ERROR : KIND_END;
			end
			phase_d       = PH_PLAIN;
			in_value_d    = 1'b0;
			high_nibble_d = 4'd0;
			draining_d    = 1'b0;
		end
	end

	// Pack results in order
	always_comb begin
		res1 = '{kind: p2_kind, data: 8'd0, run_last: 1'b1};
		if (p1_valid) begin
			res0 = '{kind: p1_kind, data: p1_byte, run_last: !p2_valid};
		end else begin
			res0 = res1;
		end
		res_count = {1'b0, p1_valid} + {1'b0, p2_valid};
	end

	// Advance state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_PLAIN;
			in_value_q    <= 1'b0;
			high_nibble_q <= 4'd0;
			draining_q    <= 1'b0;
		end else if (fire) begin
			phase_q       <= phase_d;
			in_value_q    <= in_value_d;
			high_nibble_q <= high_nibble_d;
			draining_q    <= draining_d;
		end
	end

	assign status = '{phase: phase_q, draining: draining_q};

endmodule

/* rtl/core/fud_result_queue.sv */
`timescale 1ns / 1ps

module fud_result_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [1:0]                   push_count,
	input  fud_pkg::result_t             push0,
	input  fud_pkg::result_t             push1,
	input  logic                         pop,
	output fud_pkg::result_t             head,
	output logic                         not_empty,
	output logic                         room2,
	output logic [fud_pkg::QCountW-1:0]  count
);
	import fud_pkg::*;

	result_t             mem_q [QDepth];
	logic [QPtrW-1:0]    wr_ptr_q;
	logic [QPtrW-1:0]    rd_ptr_q;
	logic [QCountW-1:0]  count_q;
	logic [QPtrW-1:0]    wr_ptr_nx;

	assign wr_ptr_nx = wr_ptr_q + QPtrW'(1);

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push_count != 2'd0) begin
			mem_q[wr_ptr_q] <= push0;
		end
		if (push_count == 2'd2) begin
			mem_q[wr_ptr_nx] <= push1;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPtrW'(push_count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPtrW'(1);
			end
			count_q <= count_q + QCountW'(push_count) - QCountW'(pop);
		end
	end

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign room2     = (count_q <= QCountW'(QDepth - 2));
	assign count     = count_q;

endmodule

/* rtl/core/form_urlencoded_decoder_unit.sv */
`timescale 1ns / 1ps

// URL-encoded form decoder.
// Input channel (in_valid/in_ready): one raw byte per request, last_byte on
// the final byte of a message. Output channel (out_valid/out_ready): one
// decoded result per request: out_kind key byte, value byte, end of pair or
// string, or error abort; run_last marks the last result of an input byte.
// Config channel (cfg_valid/cfg_ready, always ready): params_mode selects
// key=value splitting (1) or one plain string (0); write it only while idle.
// Results of a byte are visible in the cycle after its acceptance.
// One byte per cycle while the queue has room; a byte yields zero, one or
// two results. A four-entry result queue sets this: a byte is taken while
// the queue has room for two results, so a stalled receiver backs up into
// in_ready once three results are waiting.
// Reset: params_mode returns to 1, decoder state to the start of a key,
// and the result queue empties.
module form_urlencoded_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       params_mode,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] out_kind,
	output logic [7:0] out_byte,
	output logic       run_last
);
	import fud_pkg::*;

	logic                 params_mode_q;
	logic                 in_fire;
	logic                 out_fire;
	result_t              res0;
	result_t              res1;
	logic [1:0]           res_count;
	logic [1:0]           push_count;
	dec_status_t          status;
	result_t              head;
	logic                 room2;
	logic [QCountW-1:0]   q_count;

	// Mode register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			params_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			params_mode_q <= params_mode;
		end
	end

	assign in_ready   = room2;
	assign in_fire    = in_valid && in_ready;
	assign out_fire   = out_valid && out_ready;
	assign push_count = in_fire ? res_count : 2'd0;

	fud_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (in_fire),
		.pmode     (params_mode_q),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.res0      (res0),
		.res1      (res1),
		.res_count (res_count),
		.status    (status)
	);

	fud_result_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_count (push_count),
		.push0      (res0),
		.push1      (res1),
		.pop        (out_fire),
		.head       (head),
		.not_empty  (out_valid),
		.room2      (room2),
		.count      (q_count)
	);

	assign out_kind = head.kind;
	assign out_byte = head.data;
	assign run_last = head.run_last;

	// Queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCountW'(QDepth))
		else $error("result queue overflow");

	// End of message restores the start state
	a_last_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last_byte) |=> (status.phase == PH_PLAIN && !status.draining))
		else $error("decoder state not cleared after last byte");

	// End and error results carry a zero byte
	a_ctrl_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_kind == KIND_END || out_kind == KIND_ERROR)) |-> out_byte == 8'd0)
		else $error("nonzero byte on control result");

	// A byte that yields two results ends its message
	a_two_results_last: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && res_count == 2'd2) |-> last_byte)
		else $error("two results without last byte");

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import fud_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_GAP     = 30;
	localparam int MAX_LINES   = 30;
	localparam int RAND_BYTES  = 450;

	// Directed stimulus row; exp_n < 0 means the decoder model supplies the results
	typedef struct {
		logic [7:0] data;
		logic       last;
		bit         wr_mode;
		logic       mode;
		int         exp_n;
		kind_t      k0;
		logic [7:0] b0;
		kind_t      k1;
	} dir_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_mode = 1'b1;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic       run_last;

	// Decoder model state
	logic       cur_mode;
	phase_t     esc_phase;
	logic       value_field;
	logic [3:0] hi_digit;
	logic       dropping;

	result_t    expected_results[$];
	result_t    head;
	dir_row_t   rows[$];
	int         tx_idle_pct = 0;
	int         rx_stall_pct = 0;
	int         err_cnt = 0;
	int         n_bytes = 0;
	int         n_checked = 0;
	int         n_writes = 0;
	int         cycles = 0;

	form_urlencoded_decoder_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.params_mode (cfg_mode),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.run_last    (run_last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still due", cycles,
				expected_results.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic flag_mismatch(input string msg);
		if (err_cnt < MAX_LINES) $display("[%0t] MISMATCH: %s", $realtime, msg);
		err_cnt++;
	endtask

	// Hex digit value with bit 4 as the valid flag
	function automatic logic [4:0] digit_of(input logic [7:0] c);
		logic [7:0] v;
		v = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
		if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
		if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
		return {1'b0, v[3:0]};
	endfunction

	function automatic result_t mk_result(input kind_t k, input logic [7:0] b);
		result_t r;
		r.kind = k;
		r.data = b;
		r.run_last = 1'b0;
		return r;
	endfunction

	// Advance the decoder model by one byte and collect the results it causes
	task automatic decode_byte(input logic [7:0] b, input logic l,
			output result_t res[2], output int n);
		kind_t      dk;
		logic [4:0] dg;
		n = 0;
		res[0] = mk_result(KIND_KEY, 8'h00);
		res[1] = mk_result(KIND_KEY, 8'h00);
		dk = (cur_mode && value_field) ? KIND_VALUE : KIND_KEY;
		dg = digit_of(b);
		if (!dropping) begin
			if (esc_phase == PH_PLAIN) begin
				if (b == CHAR_PCT) begin
					esc_phase = PH_HIGH;
				end else if (b == CHAR_NUL || (cur_mode && b == CHAR_AMP)) begin
					res[n] = mk_result(KIND_END, 8'h00);
					n++;
					value_field = 1'b0;
					if (!cur_mode) dropping = 1'b1;
				end else if (cur_mode && !value_field && b == CHAR_EQ) begin
					value_field = 1'b1;
				end else begin
					res[n] = mk_result(dk, (b == CHAR_PLUS) ? CHAR_SPACE : b);
					n++;
				end
			end else if (!dg[4]) begin
				res[n] = mk_result(KIND_ERROR, 8'h00);
				n++;
				dropping = 1'b1;
				esc_phase = PH_PLAIN;
			end else if (esc_phase == PH_HIGH) begin
				hi_digit = dg[3:0];
				esc_phase = PH_LOW;
			end else begin
				res[n] = mk_result(dk, {hi_digit, dg[3:0]});
				n++;
				esc_phase = PH_PLAIN;
			end
		end
		// End of message closes the pair or flags a cut-short escape
		if (l) begin
			if (!dropping) begin
				res[n] = mk_result((esc_phase != PH_PLAIN) ? KIND_ERROR : KIND_END, 8'h00);
				n++;
			end
			esc_phase = PH_PLAIN;
			value_field = 1'b0;
			hi_digit = 4'h0;
			dropping = 1'b0;
		end
		if (n > 0) res[n - 1].run_last = 1'b1;
	endtask

	// Present one request and hold it until accepted
	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		n_bytes++;
	endtask

	task automatic feed_byte(input logic [7:0] b, input logic l);
		result_t res[2];
		int      n;
		send_byte(b, l);
		decode_byte(b, l, res, n);
		for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
	endtask

	// Drop valid and let every pending result drain out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_mode(input logic v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_mode <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_mode = v;
		n_writes++;
	endtask

	function automatic logic [7:0] rand_hex();
		int v;
		v = $urandom_range(15);
		if (v < 10) return 8'(8'h30 + v);
		return 8'((($urandom_range(1) != 0) ? 8'h61 : 8'h41) + v - 10);
	endfunction

	task automatic add_row(input logic [7:0] d, input logic l, input bit wr, input logic m,
			input int n, input kind_t k0, input logic [7:0] b0, input kind_t k1);
		dir_row_t r;
		r.data = d;
		r.last = l;
		r.wr_mode = wr;
		r.mode = m;
		r.exp_n = n;
		r.k0 = k0;
		r.b0 = b0;
		r.k1 = k1;
		rows.push_back(r);
	endtask

	// One message: mostly well-formed tokens, some raw noise
	task automatic send_message();
		logic [7:0] msg[$];
		int         ntok;
		int         r;
		bit         noise;
		noise = ($urandom_range(9) == 0);
		if (noise) begin
			repeat ($urandom_range(1, 12)) msg.push_back(8'($urandom_range(255)));
		end else begin
			ntok = $urandom_range(1, 8);
			repeat (ntok) begin
				r = $urandom_range(99);
				if (r < 15) begin
					msg.push_back(8'($urandom_range(255)));
				end else if (r < 40) begin
					msg.push_back(8'($urandom_range(32, 126)));
				end else if (r < 50) begin
					msg.push_back(CHAR_PLUS);
				end else if (r < 58) begin
					msg.push_back(CHAR_EQ);
				end else if (r < 66) begin
					msg.push_back(CHAR_AMP);
				end else if (r < 88) begin
					msg.push_back(CHAR_PCT);
					msg.push_back(rand_hex());
					msg.push_back(rand_hex());
				end else if (r < 92) begin
					msg.push_back(CHAR_PCT);
					if ($urandom_range(1) != 0) msg.push_back(rand_hex());
					msg.push_back(8'($urandom_range(255)));
				end else if (r < 95) begin
					msg.push_back(CHAR_NUL);
				end else begin
					msg.push_back(CHAR_PCT);
				end
			end
		end
		for (int i = 0; i < msg.size(); i++)
			feed_byte(msg[i], (i == msg.size() - 1) || (noise && $urandom_range(7) == 0));
	endtask

	// Receiver: random stall, check each result against the oldest expectation
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_stall_pct);
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result kind %0d byte %02h last %0b",
					out_kind, out_byte, run_last));
			end else begin
				head = expected_results.pop_front();
				n_checked++;
				if (out_kind !== head.kind || out_byte !== head.data ||
						run_last !== head.run_last)
					flag_mismatch($sformatf("got kind %0d byte %02h last %0b, want %0d %02h %0b",
						out_kind, out_byte, run_last, head.kind, head.data, head.run_last));
			end
		end
	end

	initial begin
		result_t res[2];
		int      n;
		int      tx_tab[4];
		int      rx_tab[4];
		int      target;
		dir_row_t r;

		tx_tab = '{0, 71, 0, 35};
		rx_tab = '{0, 0, 71, 35};
		cur_mode = 1'b1;
		esc_phase = PH_PLAIN;
		value_field = 1'b0;
		hi_digit = 4'h0;
		dropping = 1'b0;

		// Parameter mode from reset: pairs, escapes, errors, trailing separator
		add_row("k",      0, 0, 0,  1, KIND_KEY,   "k",   KIND_KEY);
		add_row(CHAR_PLUS,0, 0, 0,  1, KIND_KEY,   8'h20, KIND_KEY);
		add_row(CHAR_EQ,  0, 0, 0,  0, KIND_KEY,   8'h00, KIND_KEY);
		add_row(CHAR_EQ,  0, 0, 0,  1, KIND_VALUE, CHAR_EQ, KIND_KEY);
		add_row(CHAR_PCT, 0, 0, 0,  0, KIND_KEY,   8'h00, KIND_KEY);
		add_row("F",      0, 0, 0,  0, KIND_KEY,   8'h00, KIND_KEY);
		add_row("f",      0, 0, 0,  1, KIND_VALUE, 8'hFF, KIND_KEY);
		add_row(CHAR_AMP, 0, 0, 0,  1, KIND_END,   8'h00, KIND_KEY);
		add_row(CHAR_PCT, 0, 0, 0,  0, KIND_KEY,   8'h00, KIND_KEY);
		add_row("0",      0, 0, 0,  0, KIND_KEY,   8'h00, KIND_KEY);
		add_row("0",      0, 0, 0,  1, KIND_KEY,   8'h00, KIND_KEY);
		add_row(8'hFF,    0, 0, 0,  1, KIND_KEY,   8'hFF, KIND_KEY);
		add_row(CHAR_NUL, 0, 0, 0,  1, KIND_END,   8'h00, KIND_KEY);
		add_row(CHAR_PCT, 0, 0, 0,  0, KIND_KEY,   8'h00, KIND_KEY);
		add_row(CHAR_EQ,  0, 0, 0,  1, KIND_ERROR, 8'h00, KIND_KEY);
		add_row(CHAR_AMP, 1, 0, 0,  0, KIND_KEY,   8'h00, KIND_KEY);
		add_row(CHAR_AMP, 1, 0, 0,  2, KIND_END,   8'h00, KIND_END);
		add_row(CHAR_PCT, 0, 0, 0,  0, KIND_KEY,   8'h00, KIND_KEY);
		add_row("a",      0, 0, 0,  0, KIND_KEY,   8'h00, KIND_KEY);
		add_row("x",      1, 0, 0,  1, KIND_ERROR, 8'h00, KIND_KEY);
		add_row(CHAR_PCT, 1, 0, 0,  1, KIND_ERROR, 8'h00, KIND_KEY);
		// Mode flips mid message: value field survives plain mode
		add_row("k",      0, 0, 0, -1, KIND_KEY,   8'h00, KIND_KEY);
		add_row(CHAR_EQ,  0, 0, 0,  0, KIND_KEY,   8'h00, KIND_KEY);
		add_row("v",      0, 1, 0, -1, KIND_KEY,   8'h00, KIND_KEY);
		add_row("w",      0, 1, 1,  1, KIND_VALUE, "w",   KIND_KEY);
		// Plain mode: separators are literal, NUL ends and drops the rest
		add_row(CHAR_AMP, 0, 1, 0,  1, KIND_KEY,   CHAR_AMP, KIND_KEY);
		add_row(CHAR_NUL, 0, 0, 0,  1, KIND_END,   8'h00, KIND_KEY);
		add_row("z",      1, 0, 0,  0, KIND_KEY,   8'h00, KIND_KEY);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (rows[i]) begin
			r = rows[i];
			if (r.wr_mode) write_mode(r.mode);
			send_byte(r.data, r.last);
			decode_byte(r.data, r.last, res, n);
			if (r.exp_n < 0) begin
				for (int j = 0; j < n; j++) expected_results.push_back(res[j]);
			end else begin
				if (r.exp_n > 0) begin
					res[0] = mk_result(r.k0, r.b0);
					res[0].run_last = (r.exp_n == 1);
					expected_results.push_back(res[0]);
				end
				if (r.exp_n > 1) begin
					res[1] = mk_result(r.k1, 8'h00);
					res[1].run_last = 1'b1;
					expected_results.push_back(res[1]);
				end
			end
		end

		// Random messages over four flow-control phases, both modes in each
		for (int p = 0; p < 4; p++) begin
			for (int h = 0; h < 2; h++) begin
				write_mode(logic'(h == 0));
				tx_idle_pct = tx_tab[p];
				rx_stall_pct = rx_tab[p];
				target = n_bytes + RAND_BYTES / 2;
				while (n_bytes < target) send_message();
			end
		end

		// Drain and settle
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0)
			flag_mismatch($sformatf("%0d results never arrived", expected_results.size()));

		$display("Sent %0d bytes (%0d directed) in both modes, %0d mode writes,", n_bytes,
			rows.size(), n_writes);
		$display("checked %0d results across idle, sender-gap, receiver-stall and mixed phases",
			n_checked);
		if (err_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
